FILE: rtl/core/npsu_pkg.sv
package npsu_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int AXES       = 3;

    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths on the ports
    localparam int NP_W       = 11;
    localparam int THR_W      = 34;
    localparam int IDX_W      = 10;
    localparam int IN_COORD_W = 16;

    localparam int SUM_W      = 2 * COORD_BITS + 2;
    localparam int CMP_W      = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int CNTC_W     = (NP_W > CNT_W) ? NP_W : CNT_W;

    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 34;

    localparam logic [THR_W-1:0] THR_RESET = {THR_W{1'b1}};

    typedef logic [COORD_BITS-1:0]           coord_t;
    typedef logic [AXES-1:0][COORD_BITS-1:0] point_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_POINTS   = 1'b0,
        CFG_THRESHOLD_SQ = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    // one candidate point moving down the distance chain
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [SUM_W-1:0]  sum;
        point_t            pt;
    } cell_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] idx;
        logic [THR_W-1:0]  dist_sq;
    } best_t;

endpackage

FILE: rtl/core/npsu_point_mem.sv
module npsu_point_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [npsu_pkg::ADDR_W-1:0] wr_addr,
    input  npsu_pkg::point_t            wr_data,
    input  logic [npsu_pkg::ADDR_W-1:0] rd_addr,
    output npsu_pkg::point_t            rd_data
);
    import npsu_pkg::*;

    point_t mem [MAX_POINTS];
    point_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/npsu_axis_cell.sv
module npsu_axis_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  npsu_pkg::coord_t q_coord,
    input  npsu_pkg::cell_t  cell_in,
    output npsu_pkg::cell_t  cell_out
);
    import npsu_pkg::*;

    coord_t                  diff;
    logic [2*COORD_BITS-1:0] sq;
    cell_t                   cell_next;
    cell_t                   cell_reg;

    // this cell works on the lowest axis, then shifts the rest down
    always_comb begin
        diff = (q_coord >= cell_in.pt[0]) ? (q_coord - cell_in.pt[0])
                                          : (cell_in.pt[0] - q_coord);
        sq   = diff * diff;
        cell_next       = cell_in;
        cell_next.sum   = cell_in.sum + SUM_W'(sq);
        for (int k = 0; k < AXES - 1; k++) begin
            cell_next.pt[k] = cell_in.pt[k+1];
        end
        cell_next.pt[AXES-1] = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
        cell_reg.idx <= cell_next.idx;
        cell_reg.sum <= cell_next.sum;
        cell_reg.pt  <= cell_next.pt;
    end

    assign cell_out = cell_reg;

endmodule

FILE: rtl/core/npsu_best.sv
module npsu_best (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [npsu_pkg::THR_W-1:0] threshold,
    input  npsu_pkg::cell_t            cell_in,
    output npsu_pkg::best_t            best
);
    import npsu_pkg::*;

    best_t best_reg;
    best_t best_next;
    logic  closer;

    // strict compare keeps the lowest slot on a tie
    always_comb begin
        closer    = CMP_W'(cell_in.sum) < CMP_W'(best_reg.dist_sq);
        best_next = best_reg;
        if (start) begin
            best_next.found   = 1'b0;
            best_next.idx     = '0;
            best_next.dist_sq = threshold;
        end else if (cell_in.valid && closer) begin
            best_next.found   = 1'b1;
            best_next.idx     = cell_in.idx;
            best_next.dist_sq = CMP_W'(cell_in.sum) & CMP_W'({THR_W{1'b1}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '{found: 1'b0, idx: '0, dist_sq: THR_RESET};
        end else begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !best_reg.found |-> (best_reg.idx == '0))
        else $error("best index set without a match");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(best_reg.found) |-> $past(cell_in.valid))
        else $error("match recorded without a candidate");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!start && best_reg.found) |=> best_reg.found || $past(start))
        else $error("match lost during a search");

endmodule

FILE: rtl/core/nearest_point_search_unit.sv
// Load: accepted, no result.
// Query: result appears once all N stored points have passed the chain,
// N = min(num_points, 1024); one stored point is read per cycle from the point
// memory and flows through the three-cell distance chain. Next item accepted once the result is registered.
// Reset (aresetn low, synchronous) clears control, num_points to 0 and
// threshold_sq to all ones; point memory contents are undefined until loaded.
module nearest_point_search_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // index[9:0], coord_x[25:10], coord_y[41:26], coord_z[57:42], zero pad
    input  logic [npsu_pkg::S_DATA_W-1:0]   s_tdata,
    // op[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // nearest_index[9:0], nearest_dist_sq[43:10], zero pad
    output logic [npsu_pkg::M_DATA_W-1:0]   m_tdata,
    // found[0]
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [npsu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npsu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import npsu_pkg::*;

    localparam int X_LSB = IDX_W;
    localparam int PAD_W = M_DATA_W - IDX_W - THR_W;

    // configuration
    logic [NP_W-1:0]  num_points_reg;
    logic [THR_W-1:0] threshold_reg;

    // control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    point_t           q_reg, q_next;
    logic             v0_reg;
    logic [ADDR_W-1:0] idx0_reg;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic             m_found_reg, m_found_next;
    logic [THR_W-1:0] m_dist_reg, m_dist_next;

    logic             accept, is_query, issue, out_load, start, busy;
    logic             wr_en, in_range;
    point_t           in_pt;
    logic [IDX_W+ADDR_W-1:0] slot_ext;
    logic [IDX_W+ADDR_W-1:0] best_idx_ext;
    logic [CNTC_W-1:0] np_ext;
    logic [CNTC_W-1:0] count_sel;
    logic [IN_COORD_W+COORD_BITS-1:0] coord_ext [AXES];

    point_t  rd_data;
    cell_t   chain [AXES+1];
    best_t   best;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= '0;
            threshold_reg  <= THR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_NUM_POINTS:   num_points_reg <= cfg_data[NP_W-1:0];
                CFG_THRESHOLD_SQ: threshold_reg  <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input item
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            coord_ext[k] = {{COORD_BITS{1'b0}},
                            s_tdata[X_LSB + k*IN_COORD_W +: IN_COORD_W]};
            in_pt[k]     = coord_ext[k][COORD_BITS-1:0];
        end
        slot_ext  = {{ADDR_W{1'b0}}, s_tdata[IDX_W-1:0]};
        in_range  = slot_ext < (IDX_W+ADDR_W)'(MAX_POINTS);
        np_ext    = CNTC_W'(num_points_reg);
        count_sel = (np_ext > CNTC_W'(MAX_POINTS)) ? CNTC_W'(MAX_POINTS) : np_ext;
    end

    assign accept   = s_tvalid && s_tready;
    assign is_query = op_t'(s_tuser) == OP_QUERY;
    assign wr_en    = accept && !is_query && in_range;

    always_comb begin
        busy = v0_reg;
        for (int k = 1; k <= AXES; k++) begin
            busy = busy | chain[k].valid;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_query) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cnt_reg == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!busy && (!m_tvalid_reg || m_tready)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SEARCH: issue    = cnt_reg != count_reg;
            ST_DRAIN:  out_load = !busy && (!m_tvalid_reg || m_tready);
            default: ;
        endcase
    end

    assign start = accept && is_query;

    always_comb begin
        cnt_next   = cnt_reg;
        count_next = count_reg;
        q_next     = q_reg;
        if (start) begin
            cnt_next   = '0;
            count_next = count_sel[CNT_W-1:0];
            q_next     = in_pt;
        end else if (issue) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        best_idx_ext  = {{IDX_W{1'b0}}, best.idx};
        m_tvalid_next = m_tvalid_reg;
        m_idx_next    = m_idx_reg;
        m_found_next  = m_found_reg;
        m_dist_next   = m_dist_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_idx_next    = best_idx_ext[IDX_W-1:0];
            m_found_next  = best.found;
            m_dist_next   = best.dist_sq;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            count_reg    <= '0;
            v0_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            count_reg    <= count_next;
            v0_reg       <= issue;
            m_tvalid_reg <= m_tvalid_next;
        end
        q_reg       <= q_next;
        idx0_reg    <= cnt_reg[ADDR_W-1:0];
        m_idx_reg   <= m_idx_next;
        m_found_reg <= m_found_next;
        m_dist_reg  <= m_dist_next;
    end

    npsu_point_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_ext[ADDR_W-1:0]),
        .wr_data (in_pt),
        .rd_addr (cnt_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign chain[0] = '{valid: v0_reg, idx: idx0_reg, sum: '0, pt: rd_data};

    for (genvar k = 0; k < AXES; k++) begin : g_cell
        npsu_axis_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .q_coord  (q_reg[k]),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    npsu_best u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .threshold (threshold_reg),
        .cell_in   (chain[AXES]),
        .best      (best)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_dist_reg, m_idx_reg};
    assign m_tuser  = m_found_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !busy)
        else $error("chain busy while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (cnt_reg <= count_reg))
        else $error("search ran past point count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_query) |=> (state_reg == ST_SEARCH) && (cnt_reg == '0))
        else $error("query did not start a search");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DRAIN))
        else $error("result issued outside drain");

endmodule
